// ===== rtl/lcrpg_pkg.sv =====
// Shared types and constants for the LED chase and ramp pattern generator.
package lcrpg_pkg;

    // Frame geometry.
    localparam int NUM_LEDS  = 12;
    localparam int LED_IDX_W = 4;
    localparam int LEVEL_W   = 7;
    localparam int MODE_W    = 4;
    localparam int DELTA_W   = 8;

    // Colour and ramp constants.
    localparam logic [LEVEL_W-1:0] RAMP_TOP   = 7'd120;
    localparam logic [LEVEL_W-1:0] FIXED_STEP = 7'd4;
    localparam logic [LEVEL_W-1:0] STEP_RESET = 7'd4;
    localparam logic [LEVEL_W-1:0] BRIGHT     = 7'd127;
    localparam logic [LEVEL_W-1:0] DIM        = 7'd64;
    localparam logic [LEVEL_W-1:0] SOLID      = 7'd120;

    // Chase position reset values and last LED index.
    localparam logic [LED_IDX_W-1:0] HEAD_RESET    = 4'd0;
    localparam logic [LED_IDX_W-1:0] TRAIL_A_RESET = 4'd1;
    localparam logic [LED_IDX_W-1:0] TRAIL_B_RESET = 4'd2;
    localparam logic [LED_IDX_W-1:0] LAST_LED_IDX  = LED_IDX_W'(NUM_LEDS - 1);

    // Pattern mode codes.
    localparam logic [MODE_W-1:0] MODE_CHASE_YELLOW  = 4'd0;
    localparam logic [MODE_W-1:0] MODE_CHASE_WHITE   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_CHASE_RED     = 4'd2;
    localparam logic [MODE_W-1:0] MODE_CHASE_MAGENTA = 4'd3;
    localparam logic [MODE_W-1:0] MODE_RAMP_FIRST    = 4'd4;
    localparam logic [MODE_W-1:0] MODE_RAMP_SECOND   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_RAMP_UPPER    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_RAMP_ALL      = 4'd7;
    localparam logic [MODE_W-1:0] MODE_SOLID_RED     = 4'd8;
    localparam logic [MODE_W-1:0] MODE_RAMP_ALT      = 4'd9;

    // Command queue between front and back; depth must be a power of two.
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // One frame command: the mode and the state snapshot it needs.
    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [LED_IDX_W-1:0] head;
        logic [LED_IDX_W-1:0] trail_a;
        logic [LED_IDX_W-1:0] trail_b;
        logic [LEVEL_W-1:0]   level;
    } cmd_t;

endpackage

// ===== rtl/lcrpg_front.sv =====
// Front end: accepts ticks, advances chase and ramp state, issues frame commands.
module lcrpg_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lcrpg_pkg::LEVEL_W-1:0] cfg_wr_data,
    input  logic                          push,
    input  logic [lcrpg_pkg::MODE_W-1:0]  pattern_mode,
    input  logic                          cmd_full,
    output logic                          full,
    output logic                          cmd_push,
    output lcrpg_pkg::cmd_t               cmd
);
    import lcrpg_pkg::*;

    logic [LEVEL_W-1:0]   ramp_step_reg;
    logic [LED_IDX_W-1:0] head_reg, head_next;
    logic [LED_IDX_W-1:0] trail_a_reg, trail_a_next;
    logic [LED_IDX_W-1:0] trail_b_reg, trail_b_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [DELTA_W-1:0]   delta_reg, delta_next;

    logic                 accept;
    logic                 is_chase;
    logic                 is_ramp;
    logic [LEVEL_W-1:0]   step_sel;
    logic [DELTA_W-1:0]   delta_eff;
    logic signed [DELTA_W:0] level_sum;

    // Input side stalls only when the command queue is full.
    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    // Classify the mode.
    always_comb
    begin
        is_chase = 1'b0;
        is_ramp  = 1'b0;
        case (pattern_mode) inside
            MODE_CHASE_YELLOW, MODE_CHASE_WHITE, MODE_CHASE_RED, MODE_CHASE_MAGENTA:
                is_chase = 1'b1;
            MODE_RAMP_FIRST, MODE_RAMP_SECOND, MODE_RAMP_UPPER, MODE_RAMP_ALL,
            MODE_RAMP_ALT:
                is_ramp = 1'b1;
            default:
            begin
                is_chase = 1'b0;
                is_ramp  = 1'b0;
            end
        endcase
    end

    // Chase positions step up by one and wrap at the last LED.
    always_comb
    begin
        head_next    = (head_reg < LAST_LED_IDX) ? head_reg + 1'b1 : '0;
        trail_a_next = (trail_a_reg < LAST_LED_IDX) ? trail_a_reg + 1'b1 : '0;
        trail_b_next = (trail_b_reg < LAST_LED_IDX) ? trail_b_reg + 1'b1 : '0;
    end

    // Ramp: turn around at the bounds, then add and saturate to 0..120.
    always_comb
    begin
        if (pattern_mode == MODE_RAMP_FIRST || pattern_mode == MODE_RAMP_SECOND)
            step_sel = FIXED_STEP;
        else
            step_sel = ramp_step_reg;

        if (level_reg >= RAMP_TOP)
            delta_eff = DELTA_W'(0) - {1'b0, step_sel};
        else if (level_reg == '0)
            delta_eff = {1'b0, step_sel};
        else
            delta_eff = delta_reg;

        level_sum  = $signed({2'b00, level_reg}) + $signed({delta_eff[DELTA_W-1], delta_eff});
        delta_next = delta_eff;
        if (level_sum < 0)
            level_next = '0;
        else if (level_sum > $signed({2'b00, RAMP_TOP}))
            level_next = RAMP_TOP;
        else
            level_next = level_sum[LEVEL_W-1:0];
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ramp_step_reg <= STEP_RESET;
        else if (cfg_wr_en)
            ramp_step_reg <= cfg_wr_data;
    end

    // Animation state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= HEAD_RESET;
            trail_a_reg <= TRAIL_A_RESET;
            trail_b_reg <= TRAIL_B_RESET;
            level_reg   <= 7'd1;
            delta_reg   <= 8'd1;
        end
        else if (accept)
        begin
            if (is_chase)
            begin
                head_reg    <= head_next;
                trail_a_reg <= trail_a_next;
                trail_b_reg <= trail_b_next;
            end
            if (is_ramp)
            begin
                level_reg <= level_next;
                delta_reg <= delta_next;
            end
        end
    end

    // Command carries the state as updated by this tick; idle modes issue none.
    assign cmd_push    = accept && (is_chase || is_ramp || pattern_mode == MODE_SOLID_RED);
    assign cmd.mode    = pattern_mode;
    assign cmd.head    = head_next;
    assign cmd.trail_a = trail_a_next;
    assign cmd.trail_b = trail_b_next;
    assign cmd.level   = level_next;

endmodule

// ===== rtl/lcrpg_cmd_fifo.sv =====
// Short command queue between the front end and the LED frame emitter.
module lcrpg_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  lcrpg_pkg::cmd_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output lcrpg_pkg::cmd_t rd_data,
    output logic            nonempty
);
    import lcrpg_pkg::*;

    cmd_t                 mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_CNT_W-1:0] count_reg;
    logic                 do_wr;
    logic                 do_rd;

    assign full     = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign nonempty = (count_reg != '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && nonempty;
    assign rd_data  = mem[rd_ptr_reg];

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/lcrpg_back.sv =====
// Back end: walks the LEDs of one frame command and registers one result per cycle while its output register is free.
module lcrpg_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    input  lcrpg_pkg::cmd_t                 cmd,
    output logic                            cmd_pop,
    output logic                            empty,
    input  logic                            pop,
    output logic [lcrpg_pkg::LED_IDX_W-1:0] led_index,
    output logic [lcrpg_pkg::LEVEL_W-1:0]   green_level,
    output logic [lcrpg_pkg::LEVEL_W-1:0]   red_level,
    output logic [lcrpg_pkg::LEVEL_W-1:0]   blue_level,
    output logic                            last_led
);
    import lcrpg_pkg::*;

    cmd_t                 cmd_reg;
    logic                 busy_reg;
    logic [LED_IDX_W-1:0] led_reg;
    logic                 out_valid_reg;
    logic [LED_IDX_W-1:0] idx_out_reg;
    logic [LEVEL_W-1:0]   g_out_reg, r_out_reg, b_out_reg;
    logic                 last_out_reg;

    logic                 advance;
    logic                 frame_done;
    logic                 load;
    logic [LEVEL_W-1:0]   g_val, r_val, b_val;
    logic [1:0]           grp;
    logic                 ch_g, ch_b;

    // Output register frees up when empty or when its beat is taken.
    assign advance    = busy_reg && (!out_valid_reg || pop);
    assign frame_done = advance && (led_reg == LAST_LED_IDX);
    assign load       = cmd_valid && (!busy_reg || frame_done);
    assign cmd_pop    = load;

    // Colour of LED led_reg for the current command.
    always_comb
    begin
        grp   = led_reg[3:2];
        ch_g  = (cmd_reg.mode == MODE_CHASE_YELLOW) || (cmd_reg.mode == MODE_CHASE_WHITE);
        ch_b  = (cmd_reg.mode == MODE_CHASE_WHITE) || (cmd_reg.mode == MODE_CHASE_MAGENTA);
        g_val = '0;
        r_val = '0;
        b_val = '0;
        case (cmd_reg.mode) inside
            MODE_CHASE_YELLOW, MODE_CHASE_WHITE, MODE_CHASE_RED, MODE_CHASE_MAGENTA:
            begin
                if (led_reg == cmd_reg.head)
                begin
                    r_val = BRIGHT;
                    g_val = ch_g ? BRIGHT : '0;
                    b_val = ch_b ? BRIGHT : '0;
                end
                else if (led_reg == cmd_reg.trail_a || led_reg == cmd_reg.trail_b)
                begin
                    r_val = DIM;
                    g_val = ch_g ? DIM : '0;
                    b_val = ch_b ? DIM : '0;
                end
            end
            MODE_RAMP_FIRST:
                r_val = (grp == 2'd0) ? cmd_reg.level : '0;
            MODE_RAMP_SECOND:
            begin
                if (grp == 2'd0)
                    g_val = SOLID;
                else if (grp == 2'd1)
                    r_val = cmd_reg.level;
            end
            MODE_RAMP_UPPER:
            begin
                if (grp < 2'd2)
                    g_val = SOLID;
                else
                    r_val = cmd_reg.level;
            end
            MODE_RAMP_ALL:
                r_val = cmd_reg.level;
            MODE_SOLID_RED:
                r_val = SOLID;
            default:
            begin
                r_val = cmd_reg.level;
                g_val = led_reg[0] ? '0 : cmd_reg.level;
            end
        endcase
    end

    // Frame sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            led_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            led_reg  <= '0;
        end
        else if (frame_done)
        begin
            busy_reg <= 1'b0;
            led_reg  <= '0;
        end
        else if (advance)
        begin
            led_reg <= led_reg + 1'b1;
        end
    end

    // Command holding register.
    always_ff @(posedge clk)
    begin
        if (load)
            cmd_reg <= cmd;
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            idx_out_reg  <= led_reg;
            g_out_reg    <= g_val;
            r_out_reg    <= r_val;
            b_out_reg    <= b_val;
            last_out_reg <= (led_reg == LAST_LED_IDX);
        end
    end

    assign empty       = !out_valid_reg;
    assign led_index   = idx_out_reg;
    assign green_level = g_out_reg;
    assign red_level   = r_out_reg;
    assign blue_level  = b_out_reg;
    assign last_led    = last_out_reg;

endmodule

// ===== rtl/led_chase_ramp_pattern_generator.sv =====
// Top level of the LED chase and ramp pattern generator.
//
//   Channel   Handshake           Beat contents
//   -------   -----------------   -------------------------------------------------
//   config    cfg_wr_en           cfg_wr_data: ramp step
//   ticks     push / full         pattern_mode
//   results   empty / pop         led_index, green_level, red_level, blue_level,
//                                 last_led
//
// A tick in modes 0-9 yields twelve result beats, one per cycle from the LED
// sequencer in the back end while pop keeps up; modes 10-15 yield nothing.
// Ticks are classified and the chase and ramp state updated on acceptance; a
// four-entry command queue lets the input run ahead of the results. full rises
// only when that queue is full. Reset clears all control state at once; there
// is no clearing pass.
module led_chase_ramp_pattern_generator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lcrpg_pkg::LEVEL_W-1:0]   cfg_wr_data,
    input  logic                            push,
    output logic                            full,
    input  logic [lcrpg_pkg::MODE_W-1:0]    pattern_mode,
    output logic                            empty,
    input  logic                            pop,
    output logic [lcrpg_pkg::LED_IDX_W-1:0] led_index,
    output logic [lcrpg_pkg::LEVEL_W-1:0]   green_level,
    output logic [lcrpg_pkg::LEVEL_W-1:0]   red_level,
    output logic [lcrpg_pkg::LEVEL_W-1:0]   blue_level,
    output logic                            last_led
);
    import lcrpg_pkg::*;

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic cmd_push;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_valid;

    // Tick intake and state update.
    lcrpg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .push         (push),
        .pattern_mode (pattern_mode),
        .cmd_full     (cmd_full),
        .full         (full),
        .cmd_push     (cmd_push),
        .cmd          (front_cmd)
    );

    // Frame command queue.
    lcrpg_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_data  (front_cmd),
        .full     (cmd_full),
        .rd_en    (cmd_pop),
        .rd_data  (back_cmd),
        .nonempty (cmd_valid)
    );

    // Per-LED result emitter.
    lcrpg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (back_cmd),
        .cmd_pop     (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .led_index   (led_index),
        .green_level (green_level),
        .red_level   (red_level),
        .blue_level  (blue_level),
        .last_led    (last_led)
    );

endmodule

// ===== tb/tb_led_chase_ramp_pattern_generator.sv =====
// Self-checking testbench for the LED chase and ramp pattern generator.
module tb_led_chase_ramp_pattern_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import lcrpg_pkg::*;

    // Modes 10 to 15 are idle ticks that produce no LED beats.
    localparam logic [MODE_W-1:0] MODE_IDLE_FIRST = 4'd10;
    localparam logic [MODE_W-1:0] MODE_IDLE_LAST  = 4'd15;

    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 200;

    // One expected LED beat.
    typedef struct packed {
        logic [LED_IDX_W-1:0] led;
        logic [LEVEL_W-1:0]   green;
        logic [LEVEL_W-1:0]   red;
        logic [LEVEL_W-1:0]   blue;
        logic                 last;
    } led_beat_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_wr_en    = 1'b0;
    logic [LEVEL_W-1:0]   cfg_wr_data  = '0;
    logic                 push         = 1'b0;
    logic                 full;
    logic [MODE_W-1:0]    pattern_mode = '0;
    logic                 empty;
    logic                 pop          = 1'b0;
    logic [LED_IDX_W-1:0] led_index;
    logic [LEVEL_W-1:0]   green_level;
    logic [LEVEL_W-1:0]   red_level;
    logic [LEVEL_W-1:0]   blue_level;
    logic                 last_led;

    // Predicted animation state and the ramp step register.
    logic [LED_IDX_W-1:0]      head_pos;
    logic [LED_IDX_W-1:0]      trail_a_pos;
    logic [LED_IDX_W-1:0]      trail_b_pos;
    logic [LEVEL_W-1:0]        ramp_level;
    logic signed [DELTA_W-1:0] ramp_delta;
    logic [LEVEL_W-1:0]        ramp_step;

    led_beat_t expected_beats[$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        send_idle_pct  = 0;
    int        recv_idle_pct  = 0;
    int        hold_request   = 0;
    int        hold_left      = 0;

    led_chase_ramp_pattern_generator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .push         (push),
        .full         (full),
        .pattern_mode (pattern_mode),
        .empty        (empty),
        .pop          (pop),
        .led_index    (led_index),
        .green_level  (green_level),
        .red_level    (red_level),
        .blue_level   (blue_level),
        .last_led     (last_led)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Hard limit on the run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_led_chase_ramp_pattern_generator: FAIL");
            $finish;
        end
    end

    // Chase positions step up by one and wrap after the last LED.
    function automatic logic [LED_IDX_W-1:0] wrap_position(input logic [LED_IDX_W-1:0] pos);
        return (pos < LAST_LED_IDX) ? pos + 1'b1 : '0;
    endfunction

    // Advance the predicted state for one tick and queue the twelve LED beats of a non-idle mode.
    function automatic void predict_frame(input logic [MODE_W-1:0] mode);
        logic [LEVEL_W-1:0] step;
        logic [LEVEL_W-1:0] shade;
        logic               use_green;
        logic               use_blue;
        int                 next_level;
        led_beat_t          beat;

        if (mode >= MODE_IDLE_FIRST)
            return;

        if (mode <= MODE_CHASE_MAGENTA)
        begin
            head_pos    = wrap_position(head_pos);
            trail_a_pos = wrap_position(trail_a_pos);
            trail_b_pos = wrap_position(trail_b_pos);
        end
        else if (mode != MODE_SOLID_RED)
        begin
            // The two lower ramp modes turn around with the fixed step instead of the ramp step.
            step = (mode == MODE_RAMP_FIRST || mode == MODE_RAMP_SECOND) ? FIXED_STEP
                                                                         : ramp_step;
            if (ramp_level >= RAMP_TOP)
                ramp_delta = -$signed({1'b0, step});
            if (ramp_level == '0)
                ramp_delta = $signed({1'b0, step});
            next_level = int'(ramp_level) + int'(ramp_delta);
            if (next_level < 0)
                next_level = 0;
            if (next_level > int'(RAMP_TOP))
                next_level = int'(RAMP_TOP);
            ramp_level = LEVEL_W'(next_level);
        end

        use_green = (mode == MODE_CHASE_YELLOW || mode == MODE_CHASE_WHITE);
        use_blue  = (mode == MODE_CHASE_WHITE || mode == MODE_CHASE_MAGENTA);

        for (int led = 0; led < NUM_LEDS; led++)
        begin
            beat      = '0;
            beat.led  = LED_IDX_W'(led);
            beat.last = (led == NUM_LEDS - 1);
            case (mode)
                MODE_CHASE_YELLOW, MODE_CHASE_WHITE, MODE_CHASE_RED, MODE_CHASE_MAGENTA:
                begin
                    // The head wins over a trail at the same position.
                    if (beat.led == head_pos)
                        shade = BRIGHT;
                    else if (beat.led == trail_a_pos || beat.led == trail_b_pos)
                        shade = DIM;
                    else
                        shade = '0;
                    beat.red   = shade;
                    beat.green = use_green ? shade : '0;
                    beat.blue  = use_blue ? shade : '0;
                end
                MODE_SOLID_RED:
                    beat.red = SOLID;
                MODE_RAMP_FIRST:
                    if (led < 4)
                        beat.red = ramp_level;
                MODE_RAMP_SECOND:
                    if (led < 4)
                        beat.green = SOLID;
                    else if (led < 8)
                        beat.red = ramp_level;
                MODE_RAMP_UPPER:
                    if (led < 8)
                        beat.green = SOLID;
                    else
                        beat.red = ramp_level;
                MODE_RAMP_ALL:
                    beat.red = ramp_level;
                default:
                begin
                    beat.red = ramp_level;
                    if (led % 2 == 0)
                        beat.green = ramp_level;
                end
            endcase
            expected_beats.push_back(beat);
        end
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare every accepted result beat with the oldest expected one.
    always @(posedge clk)
    begin : check_results
        led_beat_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected beat: expected none, actual led %0d", $time,
                         led_index);
                mismatch_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                check_field("led_index", want.led, led_index);
                check_field("green_level", want.green, green_level);
                check_field("red_level", want.red, red_level);
                check_field("blue_level", want.blue, blue_level);
                check_field("last_led", want.last, last_led);
            end
        end
    end

    // Result side: random pops, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one tick, idling for random cycles first, and hold it until accepted.
    task automatic send_tick(input logic [MODE_W-1:0] mode);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push         <= 1'b1;
        pattern_mode <= mode;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_frame(mode);
        @(negedge clk);
    endtask

    // Stop sending and wait until every expected beat has come out.
    task automatic wait_drained();
        push <= 1'b0;
        while (expected_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // The ramp step is only written while the block is idle.
    task automatic write_ramp_step(input logic [LEVEL_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        ramp_step = value;
    endtask

    function automatic logic [MODE_W-1:0] random_mode();
        if ($urandom_range(99) < 12)
            return MODE_W'($urandom_range(MODE_IDLE_LAST, MODE_IDLE_FIRST));
        return MODE_W'($urandom_range(MODE_RAMP_ALT, MODE_CHASE_YELLOW));
    endfunction

    // Every mode once, idle codes included.
    task automatic test_every_mode();
        write_ramp_step(STEP_RESET);
        for (int m = 0; m <= int'(MODE_IDLE_LAST); m++)
            send_tick(MODE_W'(m));
    endtask

    // Climb the ramp to its top, then bounce it off both bounds with extreme steps.
    task automatic test_ramp_bounds();
        logic [MODE_W-1:0] ramp_modes[5] = '{MODE_RAMP_FIRST, MODE_RAMP_SECOND,
                                             MODE_RAMP_UPPER, MODE_RAMP_ALL, MODE_RAMP_ALT};
        while (ramp_level < RAMP_TOP)
            send_tick(ramp_modes[$urandom_range(4, 0)]);

        // A step above the ramp range saturates at the bound it passes.
        write_ramp_step(7'd127);
        send_tick(MODE_RAMP_ALL);
        send_tick(MODE_RAMP_ALL);
        send_tick(MODE_RAMP_ALL);

        // A zero step parks the ramp at the bound, except for the fixed-step modes.
        write_ramp_step(7'd0);
        send_tick(MODE_RAMP_ALL);
        send_tick(MODE_RAMP_ALT);
        send_tick(MODE_RAMP_FIRST);
    endtask

    // Random ticks until the given number of non-idle ones has gone in.
    task automatic run_random_phase(input int active_items, input int send_pct,
                                    input int recv_pct);
        logic [MODE_W-1:0] mode;
        int                sent;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent          = 0;
        while (sent < active_items)
        begin
            mode = random_mode();
            send_tick(mode);
            if (mode < MODE_IDLE_FIRST)
                sent++;
        end
    endtask

    // Hold the result side off long enough for the block to fill and stall its input.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
        for (int i = 0; i < 24; i++)
            send_tick(MODE_W'($urandom_range(MODE_RAMP_ALT, MODE_CHASE_YELLOW)));
        wait_drained();
    endtask

    initial
    begin
        // Predicted state after reset.
        head_pos    = HEAD_RESET;
        trail_a_pos = TRAIL_A_RESET;
        trail_b_pos = TRAIL_B_RESET;
        ramp_level  = 7'd1;
        ramp_delta  = 8'sd1;
        ramp_step   = STEP_RESET;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_every_mode();
        test_ramp_bounds();

        write_ramp_step(7'd1);
        run_random_phase(100, 28, 70);
        write_ramp_step(7'd120);
        run_random_phase(100, 70, 28);
        write_ramp_step(LEVEL_W'($urandom_range(127, 0)));
        run_random_phase(50, 0, 0);
        write_ramp_step(LEVEL_W'($urandom_range(127, 0)));
        run_random_phase(50, 0, 0);

        test_backpressure();

        wait_drained();
        if (mismatch_count == 0)
            $display("tb_led_chase_ramp_pattern_generator: PASS");
        else
            $display("tb_led_chase_ramp_pattern_generator: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lcrpg_pkg.sv
rtl/lcrpg_front.sv
rtl/lcrpg_cmd_fifo.sv
rtl/lcrpg_back.sv
rtl/led_chase_ramp_pattern_generator.sv
tb/tb_led_chase_ramp_pattern_generator.sv
